// ----- rtl/core/c2d_pkg.sv -----
`default_nettype none

package c2d_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS = 48;

  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_COEF_TOP     = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_COEF_MID     = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_COEF_BOTTOM  = 3'd4;

  // Register field widths and reset values
  localparam int unsigned IMG_W_BITS = 11;
  localparam int unsigned IMG_H_BITS = 16;
  localparam logic [IMG_W_BITS-1:0] IMG_W_RESET = 11'd1024;
  localparam logic [IMG_H_BITS-1:0] IMG_H_RESET = 16'd1024;

  // Coefficient slot pitch inside one coefficient row register
  localparam int unsigned SLOT_BITS = 16;

  // Kernel geometry
  localparam int unsigned KSIZE = 3;
  localparam int unsigned TAPS  = KSIZE * KSIZE;

  // Row counter runs up to height + 1
  localparam int unsigned ROW_CNT_BITS = IMG_H_BITS + 1;

  // Where the current output pixel sits relative to the frame border
  typedef struct packed {
    logic [KSIZE-1:0] row_ok;
    logic [KSIZE-1:0] col_ok;
    logic             last;
  } c2d_pos_t;

endpackage

`default_nettype wire

// ----- rtl/core/c2d_in_if.sv -----
`default_nettype none

interface c2d_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] pixel;
  logic                          pad;

  modport source (output valid, output pixel, output pad, input ready);
  modport sink   (input valid, input pixel, input pad, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/c2d_out_if.sv -----
`default_nettype none

interface c2d_out_if #(
  parameter int SUM_BITS = 35
);
  logic                       valid;
  logic                       ready;
  logic signed [SUM_BITS-1:0] conv_sum;
  logic                       frame_end;

  modport source (output valid, output conv_sum, output frame_end, input ready);
  modport sink   (input valid, input conv_sum, input frame_end, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/c2d_ram.sv -----
`default_nettype none

module c2d_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/c2d_mac.sv -----
`default_nettype none

module c2d_mac #(
  parameter int SAMPLE_BITS = 16,
  parameter int COEF_BITS   = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst_n,
  input  wire logic                                      in_valid,
  output logic                                           in_ready,
  input  wire logic signed [SAMPLE_BITS-1:0]             samp [c2d_pkg::TAPS],
  input  wire logic signed [COEF_BITS-1:0]               coef [c2d_pkg::TAPS],
  input  wire logic                                      in_last,
  output logic                                           out_valid,
  input  wire logic                                      out_ready,
  output logic signed [SAMPLE_BITS+COEF_BITS+2:0]        out_sum,
  output logic                                           out_last
);

  import c2d_pkg::*;

  localparam int PROD_BITS   = SAMPLE_BITS + COEF_BITS;
  localparam int ROWSUM_BITS = PROD_BITS + 2;
  localparam int SUM_BITS    = PROD_BITS + 3;

  logic                          prod_v_r;
  logic                          prod_last_r;
  logic signed [PROD_BITS-1:0]   prod_r [TAPS];
  logic                          row_v_r;
  logic                          row_last_r;
  logic signed [ROWSUM_BITS-1:0] row_r [KSIZE];
  logic                          out_v_r;
  logic                          out_last_r;
  logic signed [SUM_BITS-1:0]    out_sum_r;

  logic signed [PROD_BITS-1:0]   prod_nxt [TAPS];
  logic signed [ROWSUM_BITS-1:0] row_nxt [KSIZE];
  logic signed [SUM_BITS-1:0]    sum_nxt;
  logic                          out_en;
  logic                          row_en;
  logic                          prod_en;

  // each stage loads when empty or when its successor takes its item
  assign out_en   = !out_v_r || out_ready;
  assign row_en   = !row_v_r || out_en;
  assign prod_en  = !prod_v_r || row_en;
  assign in_ready = prod_en;

  // nine products, one per window tap
  always_comb begin
    for (int i = 0; i < TAPS; i++) begin
      prod_nxt[i] = PROD_BITS'(samp[i]) * PROD_BITS'(coef[i]);
    end
  end

  // one partial sum per kernel row
  always_comb begin
    for (int j = 0; j < KSIZE; j++) begin
      row_nxt[j] = ROWSUM_BITS'(prod_r[KSIZE*j]) + ROWSUM_BITS'(prod_r[KSIZE*j+1])
                 + ROWSUM_BITS'(prod_r[KSIZE*j+2]);
    end
  end

  // final sum of the three rows
  assign sum_nxt = SUM_BITS'(row_r[0]) + SUM_BITS'(row_r[1]) + SUM_BITS'(row_r[2]);

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
      row_v_r  <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (prod_en) prod_v_r <= in_valid;
      if (row_en)  row_v_r  <= prod_v_r;
      if (out_en)  out_v_r  <= row_v_r;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (prod_en) begin
      prod_r      <= prod_nxt;
      prod_last_r <= in_last;
    end
    if (row_en) begin
      row_r      <= row_nxt;
      row_last_r <= prod_last_r;
    end
    if (out_en) begin
      out_sum_r  <= sum_nxt;
      out_last_r <= row_last_r;
    end
  end

  assign out_valid = out_v_r;
  assign out_sum   = out_sum_r;
  assign out_last  = out_last_r;

endmodule

`default_nettype wire

// ----- rtl/core/conv2d_3x3_zero_pad.sv -----
// Streaming 3x3 convolution with zero padding, one pixel per clock unless stalled.
// in_stream carries pixels of a frame in raster order (pixel, pad); out_stream
// carries conv_sum and frame_end. Both use valid/ready; an item moves on a
// rising edge with valid and ready high. cfg_we/cfg_index/cfg_wdata write the
// geometry and kernel rows; write them only while the block is idle. Writing
// width or height restarts the frame.
// Result for pixel (r,c) is produced by the item with linear index
// (r+1)*W+c+1; after W*H pixels send W+1 pad items to flush, and the last
// result carries frame_end. Throughput is one item per clock while out_stream
// is ready; an item passes through the item register, the product register,
// the row-sum register and the result register in turn. The two line buffers
// are single-write RAMs, read at accept and written when the item leaves
// the item register; a forward register covers a reread of the address
// just written.
// Reset clears the counters, window, width/height (1024) and kernel (zero);
// the line buffers are not cleared, their stale contents are masked at the
// frame border. When out_stream stalls, the pipeline fills its empty stages
// and then in_stream.ready drops; nothing is lost.
`default_nettype none

module conv2d_3x3_zero_pad #(
  parameter int MAX_WIDTH   = 1024,
  parameter int SAMPLE_BITS = 16,
  parameter int COEF_BITS   = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  c2d_in_if.sink                                     in_stream,
  c2d_out_if.source                                  out_stream,
  input  wire logic                                  cfg_we,
  input  wire logic [c2d_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  wire logic [c2d_pkg::CFG_DATA_BITS-1:0]     cfg_wdata
);

  import c2d_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);

  // configuration
  logic [IMG_W_BITS-1:0]    width_r;
  logic [IMG_H_BITS-1:0]    height_r;
  logic [CFG_DATA_BITS-1:0] coef_r [KSIZE];

  // frame position
  logic [AW-1:0]           col_r;
  logic [ROW_CNT_BITS-1:0] row_r;

  // item register
  logic                          s1_v_r;
  logic [AW-1:0]                 addr_r;
  logic signed [SAMPLE_BITS-1:0] s_r;
  c2d_pos_t                      pos_r;
  logic                          emit_r;
  logic                          fwd_r;
  logic [SAMPLE_BITS-1:0]        fwd_older_r;
  logic [SAMPLE_BITS-1:0]        fwd_newer_r;

  // two previous window columns, three rows each
  logic signed [SAMPLE_BITS-1:0] win_r [2*KSIZE];

  logic [WW-1:0]                 w_eff;
  logic [ROW_CNT_BITS-1:0]       h_eff;
  logic                          acc;
  logic                          s1_adv;
  logic [AW-1:0]                 c_in;
  logic                          c_in_nz;
  logic [ROW_CNT_BITS-1:0]       r_sel;
  logic [AW-1:0]                 c_sel;
  c2d_pos_t                      pos_nxt;
  logic                          emit_nxt;
  logic [AW-1:0]                 col_nxt;
  logic [ROW_CNT_BITS-1:0]       row_nxt;
  logic signed [SAMPLE_BITS-1:0] s_nxt;
  logic                          fwd_nxt;

  logic [SAMPLE_BITS-1:0]        older_rd;
  logic [SAMPLE_BITS-1:0]        newer_rd;
  logic [SAMPLE_BITS-1:0]        older_eff;
  logic [SAMPLE_BITS-1:0]        newer_eff;
  logic signed [SAMPLE_BITS-1:0] newcol [KSIZE];
  logic signed [SAMPLE_BITS-1:0] grid [TAPS];
  logic signed [SAMPLE_BITS-1:0] samp [TAPS];
  logic signed [COEF_BITS-1:0]   coef [TAPS];
  logic                          mac_in_ready;

  // effective geometry: width 0 acts as 1, clamp to the line buffer
  always_comb begin
    if (width_r == '0) begin
      w_eff = WW'(1);
    end else if (32'(width_r) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_r);
    end
    h_eff = (height_r == '0) ? ROW_CNT_BITS'(1) : ROW_CNT_BITS'(height_r);
  end

  assign acc    = in_stream.valid && in_stream.ready;
  assign s1_adv = s1_v_r && (!emit_r || mac_in_ready);
  assign in_stream.ready = !s1_v_r || s1_adv;

  // position of the arriving item and of the output pixel it completes
  always_comb begin
    c_in    = (WW'(col_r) >= w_eff) ? '0 : col_r;
    c_in_nz = (c_in != '0);
    if (c_in_nz) begin
      emit_nxt = (row_r >= ROW_CNT_BITS'(1));
      r_sel    = row_r - ROW_CNT_BITS'(1);
      c_sel    = c_in - AW'(1);
    end else begin
      emit_nxt = (row_r >= ROW_CNT_BITS'(2));
      r_sel    = row_r - ROW_CNT_BITS'(2);
      c_sel    = AW'(w_eff - WW'(1));
    end
    pos_nxt.row_ok[0] = (r_sel != '0);
    pos_nxt.row_ok[1] = (r_sel < h_eff);
    pos_nxt.row_ok[2] = ({1'b0, r_sel} + (ROW_CNT_BITS+1)'(1)) < {1'b0, h_eff};
    pos_nxt.col_ok[0] = (c_sel != '0);
    pos_nxt.col_ok[1] = 1'b1;
    pos_nxt.col_ok[2] = (WW'(c_sel) + WW'(1)) < w_eff;
    pos_nxt.last      = !c_in_nz && (row_r == h_eff + ROW_CNT_BITS'(1));

    // counter advance
    if (pos_nxt.last) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if ((WW'(c_in) + WW'(1)) >= w_eff) begin
      col_nxt = '0;
      row_nxt = row_r + ROW_CNT_BITS'(1);
    end else begin
      col_nxt = c_in + AW'(1);
      row_nxt = row_r;
    end

    s_nxt   = in_stream.pad ? '0 : in_stream.pixel;
    // the item leaving now writes the address we are about to read
    fwd_nxt = s1_adv && (addr_r == c_in);
  end

  // configuration registers and frame counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= IMG_W_RESET;
      height_r <= IMG_H_RESET;
      coef_r   <= '{default: '0};
      col_r    <= '0;
      row_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH: begin
          width_r <= cfg_wdata[IMG_W_BITS-1:0];
          col_r   <= '0;
          row_r   <= '0;
        end
        REG_IMAGE_HEIGHT: begin
          height_r <= cfg_wdata[IMG_H_BITS-1:0];
          col_r    <= '0;
          row_r    <= '0;
        end
        REG_COEF_TOP:    coef_r[0] <= cfg_wdata;
        REG_COEF_MID:    coef_r[1] <= cfg_wdata;
        REG_COEF_BOTTOM: coef_r[2] <= cfg_wdata;
        default: ;
      endcase
    end else if (acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // item register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (acc) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  // item register payload
  always_ff @(posedge clk) begin
    if (acc) begin
      addr_r      <= c_in;
      s_r         <= s_nxt;
      pos_r       <= pos_nxt;
      emit_r      <= emit_nxt;
      fwd_r       <= fwd_nxt;
      fwd_older_r <= newer_eff;
      fwd_newer_r <= s_r;
    end
  end

  // line buffers: older row and newer row
  c2d_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WIDTH)) u_line_older (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (addr_r),
    .wdata (newer_eff),
    .re    (acc),
    .raddr (c_in),
    .rdata (older_rd)
  );

  c2d_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WIDTH)) u_line_newer (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (addr_r),
    .wdata (s_r),
    .re    (acc),
    .raddr (c_in),
    .rdata (newer_rd)
  );

  assign older_eff = fwd_r ? fwd_older_r : older_rd;
  assign newer_eff = fwd_r ? fwd_newer_r : newer_rd;

  // column entering the window
  assign newcol[0] = older_eff;
  assign newcol[1] = newer_eff;
  assign newcol[2] = s_r;

  // window shift
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '{default: '0};
    end else if (s1_adv) begin
      for (int dy = 0; dy < KSIZE; dy++) begin
        win_r[dy]         <= win_r[KSIZE+dy];
        win_r[KSIZE + dy] <= newcol[dy];
      end
    end
  end

  // 3x3 neighbourhood with taps outside the frame zeroed
  always_comb begin
    for (int dy = 0; dy < KSIZE; dy++) begin
      grid[KSIZE*dy]     = win_r[dy];
      grid[KSIZE*dy + 1] = win_r[KSIZE+dy];
      grid[KSIZE*dy + 2] = newcol[dy];
      for (int dx = 0; dx < KSIZE; dx++) begin
        samp[KSIZE*dy + dx] = (pos_r.row_ok[dy] && pos_r.col_ok[dx]) ?
                              grid[KSIZE*dy + dx] : '0;
      end
    end
  end

  // flipped kernel: tap p uses entry 8-p
  for (genvar p = 0; p < TAPS; p++) begin : g_coef
    localparam int K = TAPS - 1 - p;
    assign coef[p] = coef_r[K/KSIZE][SLOT_BITS*(K%KSIZE) +: COEF_BITS];
  end

  c2d_mac #(.SAMPLE_BITS(SAMPLE_BITS), .COEF_BITS(COEF_BITS)) u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_v_r && emit_r),
    .in_ready  (mac_in_ready),
    .samp      (samp),
    .coef      (coef),
    .in_last   (pos_r.last),
    .out_valid (out_stream.valid),
    .out_ready (out_stream.ready),
    .out_sum   (out_stream.conv_sum),
    .out_last  (out_stream.frame_end)
  );

`ifndef SYNTHESIS
  // column counter stays inside the row after each item
  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> (WW'(col_r) < w_eff))
    else $error("column counter beyond image width");

  // the item closing a frame restarts both counters
  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && pos_nxt.last) |=> (col_r == '0 && row_r == '0))
    else $error("counters not cleared at frame end");

  // an accepted item is held in the item register
  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> s1_v_r)
    else $error("accepted item lost");

  // a stalled item keeps its address and sample
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !s1_adv) |=> (s1_v_r && $stable(addr_r) && $stable(s_r)))
    else $error("stalled item changed");
`endif

endmodule

`default_nettype wire

// ----- dv/conv_checker.sv -----
// Watches the pixel, result and register ports of the 3x3 convolution block,
// keeps its own copy of the line stores, window and counters, and compares
// every result against the sum it worked out when the causing item went in.
module conv_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  c2d_in_if                                 in_mon,
  c2d_out_if                                out_mon,
  input  logic                              cfg_we,
  input  logic [c2d_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [c2d_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
  output int                                fail_total,
  output int                                sums_pending
);

  import c2d_pkg::*;

  localparam int MAX_COLS = 1024;

  typedef struct packed {
    logic signed [34:0] sum;
    logic               frame_end;
  } conv_result_t;

  // Register copies
  logic [IMG_W_BITS-1:0] reg_w;
  logic [IMG_H_BITS-1:0] reg_h;
  logic [47:0]           coef_row [KSIZE];

  // Line stores, two-column window and raster position
  logic signed [15:0] store_old [MAX_COLS];
  logic signed [15:0] store_new [MAX_COLS];
  logic signed [15:0] win [6];
  int                 col_cnt;
  int                 row_cnt;

  conv_result_t sums_due [$];
  int           bad;

  // Out-of-range width is clamped, zero acts as one
  function automatic int active_width();
    if (reg_w == 0) return 1;
    if (reg_w > MAX_COLS) return MAX_COLS;
    return int'(reg_w);
  endfunction

  // Kernel entry k, signed slot of its coefficient row
  function automatic logic signed [15:0] tap(input int k);
    logic [47:0] row_bits;
    row_bits = coef_row[k / KSIZE];
    return row_bits[(k % KSIZE) * SLOT_BITS +: 16];
  endfunction

  task automatic report(input string msg);
    bad++;
    if (bad <= 10) $display("%s", msg);
  endtask

  // One item through the window: queue the sum it brings out, then shift state
  task automatic slide_window(input logic signed [15:0] px, input logic pd);
    int                 w;
    int                 h;
    int                 col;
    int                 row;
    int                 r;
    int                 c;
    int                 yy;
    int                 xx;
    logic signed [15:0] s;
    logic signed [15:0] fresh [3];
    logic signed [15:0] nbhd [3][3];
    bit                 produce;
    bit                 closes;
    longint             acc;
    conv_result_t       res;
    w = active_width();
    h = (reg_h == 0) ? 1 : int'(reg_h);
    col = col_cnt;
    row = row_cnt;
    if (col >= w) col = 0;
    s = pd ? 16'sd0 : px;
    fresh[0] = store_old[col];
    fresh[1] = store_new[col];
    fresh[2] = s;
    for (int dy = 0; dy < 3; dy++) begin
      nbhd[dy][0] = win[dy];
      nbhd[dy][1] = win[3 + dy];
      nbhd[dy][2] = (col >= 1) ? fresh[dy] : 16'sd0;
    end
    // column zero finishes the previous row's last pixel
    if (col >= 1) begin
      produce = (row >= 1);
      r = row - 1;
      c = col - 1;
    end else begin
      produce = (row >= 2);
      r = row - 2;
      c = w - 1;
    end
    closes = (col == 0) && (row == h + 1);
    if (produce) begin
      acc = 0;
      for (int dy = 0; dy < 3; dy++) begin
        for (int dx = 0; dx < 3; dx++) begin
          yy = r - 1 + dy;
          xx = c - 1 + dx;
          // zero padding: anything outside the frame is left out
          if (yy >= 0 && yy < h && xx >= 0 && xx < w)
            acc += longint'(tap((2 - dy) * 3 + (2 - dx))) * longint'(nbhd[dy][dx]);
        end
      end
      res.sum = acc[34:0];
      res.frame_end = closes;
      sums_due.push_back(res);
    end
    store_old[col] = store_new[col];
    store_new[col] = s;
    for (int dy = 0; dy < 3; dy++) begin
      win[dy] = win[3 + dy];
      win[3 + dy] = fresh[dy];
    end
    if (closes) begin
      col_cnt = 0;
      row_cnt = 0;
    end else begin
      col++;
      if (col >= w) begin
        col = 0;
        row++;
      end
      col_cnt = col;
      row_cnt = row;
    end
  endtask

  always @(posedge clk) begin
    conv_result_t want;
    if (!rst_n) begin
      reg_w = IMG_W_RESET;
      reg_h = IMG_H_RESET;
      for (int k = 0; k < KSIZE; k++) coef_row[k] = '0;
      for (int i = 0; i < MAX_COLS; i++) begin
        store_old[i] = '0;
        store_new[i] = '0;
      end
      for (int i = 0; i < 6; i++) win[i] = '0;
      col_cnt = 0;
      row_cnt = 0;
      sums_due.delete();
      bad = 0;
    end else begin
      // register writes; geometry restarts the frame
      if (cfg_we) begin
        case (cfg_index)
          REG_IMAGE_WIDTH: begin
            reg_w = cfg_wdata[IMG_W_BITS-1:0];
            col_cnt = 0;
            row_cnt = 0;
          end
          REG_IMAGE_HEIGHT: begin
            reg_h = cfg_wdata[IMG_H_BITS-1:0];
            col_cnt = 0;
            row_cnt = 0;
          end
          REG_COEF_TOP:    coef_row[0] = cfg_wdata[47:0];
          REG_COEF_MID:    coef_row[1] = cfg_wdata[47:0];
          REG_COEF_BOTTOM: coef_row[2] = cfg_wdata[47:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) slide_window(in_mon.pixel, in_mon.pad);
      // results against the oldest pending sum
      if (out_mon.valid && out_mon.ready) begin
        if (sums_due.size() == 0) begin
          report($sformatf("unexpected result: sum %0d end %0b",
                           out_mon.conv_sum, out_mon.frame_end));
        end else begin
          want = sums_due.pop_front();
          if (want.sum !== out_mon.conv_sum || want.frame_end !== out_mon.frame_end)
            report($sformatf("result mismatch: expected sum %0d end %0b, got sum %0d end %0b",
                             want.sum, want.frame_end, out_mon.conv_sum,
                             out_mon.frame_end));
        end
      end
    end
    fail_total <= bad;
    sums_pending <= sums_due.size();
  end

endmodule

// ----- dv/tb_top.sv -----
// Drives frames of pixels into the 3x3 convolution block, reprograms geometry
// and kernel between frames, throttles both channels and gives the verdict.
module tb_top;
  import c2d_pkg::*;

  localparam int STALL_LIMIT  = 3000;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 400;

  logic clk = 1'b0;
  logic rst_n;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_wdata;

  c2d_in_if  #(.SAMPLE_BITS(16)) in_ch ();
  c2d_out_if #(.SUM_BITS(35))    out_ch ();

  int fail_total;
  int sums_pending;
  bit gaps_on = 1'b1;
  int hold_asked = 0;
  int items_sent = 0;
  int quiet_cycles = 0;

  conv2d_3x3_zero_pad u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stream  (in_ch),
    .out_stream (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  conv_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .fail_total   (fail_total),
    .sums_pending (sums_pending)
  );

  always #5 clk = ~clk;

  // Watchdog: too long with no item moving on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: random back-pressure, plus a long hold-off on request
  initial begin
    int served;
    served = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_asked > served) begin
        served++;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ch.ready <= !(gaps_on && $urandom_range(0, 99) < 29);
    end
  end

  // Mostly random samples, with the extremes fairly often
  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(0, 9))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return 16'sh0000;
      3:       return -16'sd1;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [47:0] rand_coef_row();
    logic [47:0] row_bits;
    for (int k = 0; k < KSIZE; k++) begin
      case ($urandom_range(0, 7))
        0:       row_bits[k*SLOT_BITS +: 16] = 16'h8000;
        1:       row_bits[k*SLOT_BITS +: 16] = 16'h7FFF;
        2:       row_bits[k*SLOT_BITS +: 16] = 16'h0000;
        default: row_bits[k*SLOT_BITS +: 16] = 16'($urandom);
      endcase
    end
    return row_bits;
  endfunction

  task automatic offer(input logic signed [15:0] px, input logic pd);
    while (gaps_on && $urandom_range(0, 99) < 29) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.pixel <= px;
    in_ch.pad   <= pd;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  // Leaves cfg_we high; the caller lowers it after the last write
  task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // Stop offering, let every result drain and the pipeline go quiet
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sums_pending != 0);
    repeat (8) @(posedge clk);
  endtask

  // One frame: W*H pixels then W+1 flush items, with some noise in both parts;
  // cut >= 0 stops the frame early after that many items
  task automatic send_frame(input int w, input int h, input int cut);
    int  total;
    logic pd;
    total = w * h + w + 1;
    if (cut >= 0 && cut < total) total = cut;
    for (int k = 0; k < total; k++) begin
      if (k < w * h) pd = ($urandom_range(0, 99) < 4);
      else pd = ($urandom_range(0, 99) >= 10);
      offer(rand_sample(), pd);
    end
  endtask

  initial begin
    int phase;
    int start_items;
    int w_code;
    int h_code;
    int w_eff;
    int h_eff;
    int frames;
    int cut;
    bit geo;
    bit cut_prev;

    in_ch.valid <= 1'b0;
    in_ch.pixel <= '0;
    in_ch.pad   <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_index   <= REG_IMAGE_WIDTH;
    cfg_wdata   <= '0;
    rst_n       <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Full-scale kernel on full-scale samples; last flush item carries a pixel
    cfg_write(REG_IMAGE_WIDTH, 3);
    cfg_write(REG_IMAGE_HEIGHT, 3);
    cfg_write(REG_COEF_TOP, {3{16'h8000}});
    cfg_write(REG_COEF_MID, {3{16'h8000}});
    cfg_write(REG_COEF_BOTTOM, {3{16'h8000}});
    cfg_we <= 1'b0;
    repeat (9) offer(16'sh8000, 1'b0);
    repeat (3) offer(16'sh7FFF, 1'b1);
    offer(16'sh7FFF, 1'b0);
    settle();

    // Zero width and height both act as one: a single-pixel frame
    cfg_write(REG_IMAGE_WIDTH, 0);
    cfg_write(REG_IMAGE_HEIGHT, 0);
    cfg_write(REG_COEF_MID, {16'h7FFF, 16'h8000, 16'h0001});
    cfg_we <= 1'b0;
    offer(16'sh7FFF, 1'b0);
    offer(16'sh5555, 1'b1);
    offer(-16'sd1, 1'b1);
    settle();

    // Tallest frame, abandoned after one result, then restarted by geometry
    cfg_write(REG_IMAGE_WIDTH, 2);
    cfg_write(REG_IMAGE_HEIGHT, 16'hFFFF);
    cfg_we <= 1'b0;
    repeat (4) offer(rand_sample(), 1'b0);
    settle();
    cfg_write(REG_IMAGE_WIDTH, 2);
    cfg_write(REG_IMAGE_HEIGHT, 2);
    cfg_write(REG_COEF_TOP, {16'h7FFF, 16'hFFFF, 16'h8000});
    cfg_write(REG_COEF_BOTTOM, {16'h0001, 16'h7FFF, 16'h8000});
    cfg_we <= 1'b0;
    offer(16'sh8000, 1'b0);
    offer(16'sh7FFF, 1'b1);
    offer(16'sh7FFF, 1'b0);
    offer(-16'sd1, 1'b0);
    repeat (3) offer(16'sh2AAA, 1'b1);
    settle();

    // Random phases: new geometry and/or kernel, then a few frames
    w_code = 2;
    h_code = 2;
    cut_prev = 1'b0;
    phase = 0;
    start_items = items_sent;
    while (items_sent - start_items < RANDOM_ITEMS || phase < 4) begin
      phase++;
      gaps_on <= (phase != 4);
      if (phase == 2) hold_asked <= hold_asked + 1;
      frames = (phase == 4) ? 3 : $urandom_range(1, 3);
      cut = ($urandom_range(0, 9) == 0) ? 0 : -1;
      geo = cut_prev || phase == 1 || phase == 4 || $urandom_range(0, 9) < 7;
      if (geo) begin
        w_code = $urandom_range(1, 12);
        h_code = $urandom_range(1, 8);
        case ($urandom_range(0, 19))
          0: w_code = 0;
          1: begin
            w_code = $urandom_range(1025, 2047);
            h_code = $urandom_range(1, 65535);
            cut = $urandom_range(5, 60);
            frames = 1;
          end
          2: h_code = 0;
          3: begin
            w_code = $urandom_range(1, 8);
            h_code = 65535;
            cut = $urandom_range(w_code * 3, w_code * 6);
            frames = 1;
          end
          default: ;
        endcase
        // the unbroken stretch gets frames of some size
        if (phase == 4) begin
          w_code = $urandom_range(8, 12);
          h_code = $urandom_range(6, 8);
          cut = -1;
          frames = 3;
        end
        cfg_write(REG_IMAGE_WIDTH, w_code);
        cfg_write(REG_IMAGE_HEIGHT, h_code);
      end
      if ($urandom_range(0, 1)) cfg_write(REG_COEF_TOP, rand_coef_row());
      if ($urandom_range(0, 1)) cfg_write(REG_COEF_MID, rand_coef_row());
      if ($urandom_range(0, 1)) cfg_write(REG_COEF_BOTTOM, rand_coef_row());
      cfg_we <= 1'b0;
      w_eff = (w_code == 0) ? 1 : ((w_code > 1024) ? 1024 : w_code);
      h_eff = (h_code == 0) ? 1 : h_code;
      // a short cut request lands somewhere inside the last frame
      if (cut == 0) cut = $urandom_range(1, w_eff * h_eff + w_eff);
      for (int f = 0; f < frames; f++)
        send_frame(w_eff, h_eff, (f == frames - 1) ? cut : -1);
      cut_prev = (cut >= 0);
      settle();
    end

    // Widest row at the width clamp: the whole row and the first flush items
    gaps_on <= 1'b1;
    cfg_write(REG_IMAGE_WIDTH, $urandom_range(0, 1) ? 1024 : 2047);
    cfg_write(REG_IMAGE_HEIGHT, 1);
    cfg_write(REG_COEF_MID, rand_coef_row());
    cfg_we <= 1'b0;
    send_frame(1024, 1, 1024 + 4);
    settle();

    if (fail_total == 0 && sums_pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
